// ===== sv/nccs_pkg.sv =====
// Package for the NAND command cycle sequencer.
// Holds opcodes, result kinds, register indexes and the controller/datapath types.
// No dependencies.
`timescale 1ns / 1ps

package nccs_pkg;

	// Command opcodes, standard ONFI values.
	localparam logic [7:0] OP_READ0     = 8'h00;
	localparam logic [7:0] OP_PAGEPROG  = 8'h10;
	localparam logic [7:0] OP_READSTART = 8'h30;
	localparam logic [7:0] OP_ERASE1    = 8'h60;
	localparam logic [7:0] OP_STATUS    = 8'h70;
	localparam logic [7:0] OP_SEQIN     = 8'h80;
	localparam logic [7:0] OP_ERASE2    = 8'hD0;
	localparam logic [7:0] OP_RESET     = 8'hFF;

	// Result kinds.
	localparam logic [1:0] KIND_BUS   = 2'd0;
	localparam logic [1:0] KIND_CTRL  = 2'd1;
	localparam logic [1:0] KIND_DELAY = 2'd2;
	localparam logic [1:0] KIND_POLL  = 2'd3;

	// Configuration register indexes and reset values.
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_CHIP_DELAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_BUS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd2;
	localparam logic [9:0]  CHIP_DELAY_RESET = 10'd25;
	localparam logic [15:0] CAPACITY_RESET   = 16'd512;
	localparam logic [15:0] BIG_CAPACITY_MB  = 16'd128;

	// Which result item the datapath builds in a given cycle.
	typedef enum logic [3:0] {
		SEL_CMD,
		SEL_COL0,
		SEL_COL1,
		SEL_ROW0,
		SEL_ROW1,
		SEL_ROW2,
		SEL_CTRL,
		SEL_DELAY,
		SEL_CMD2,
		SEL_POLL
	} sel_t;

	// Tail of the sequence after the control-change cycle.
	typedef enum logic [1:0] {
		OPC_END,
		OPC_RESET,
		OPC_READ0,
		OPC_OTHER
	} op_class_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic emit;
		logic last;
		sel_t sel;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic      col_present;
		logic      row_present;
		logic      third_row;
		op_class_t op_class;
	} status_t;

endpackage

// ===== sv/nccs_ctrl.sv =====
// Controller state machine of the NAND command cycle sequencer.
// Steps through the bus cycles of one command; depends on nccs_pkg.
`timescale 1ns / 1ps

module nccs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  nccs_pkg::status_t status,
	output nccs_pkg::cmd_t   cmd,
	output logic             busy
);

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_CMD     = 13'b0000000000010,
		S_COL0    = 13'b0000000000100,
		S_COL1    = 13'b0000000001000,
		S_ROW0    = 13'b0000000010000,
		S_ROW1    = 13'b0000000100000,
		S_ROW2    = 13'b0000001000000,
		S_CTRL    = 13'b0000010000000,
		S_DLY_PRE = 13'b0000100000000,
		S_CMD2    = 13'b0001000000000,
		S_CTRL2   = 13'b0010000000000,
		S_POLL    = 13'b0100000000000,
		S_DLY     = 13'b1000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next-state selection.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_CMD;
			end
			S_CMD: begin
				if (status.col_present) state_d = S_COL0;
				else if (status.row_present) state_d = S_ROW0;
				else state_d = S_CTRL;
			end
			S_COL0: state_d = S_COL1;
			S_COL1: begin
				state_d = status.row_present ? S_ROW0 : S_CTRL;
			end
			S_ROW0: state_d = S_ROW1;
			S_ROW1: begin
				state_d = status.third_row ? S_ROW2 : S_CTRL;
			end
			S_ROW2: state_d = S_CTRL;
			S_CTRL: begin
				case (status.op_class)
					nccs_pkg::OPC_END:   state_d = S_IDLE;
					nccs_pkg::OPC_RESET: state_d = S_DLY_PRE;
					nccs_pkg::OPC_READ0: state_d = S_CMD2;
					default:             state_d = S_DLY;
				endcase
			end
			S_DLY_PRE: state_d = S_CMD2;
			S_CMD2:    state_d = S_CTRL2;
			S_CTRL2: begin
				state_d = (status.op_class == nccs_pkg::OPC_RESET) ? S_POLL : S_DLY;
			end
			S_POLL: state_d = S_IDLE;
			S_DLY:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands for the datapath. A request is taken only in idle, one item is built per
	// non-idle state, and the final item is the one before idle.
	always_comb begin
		cmd.load = start && (state_q == S_IDLE);
		cmd.emit = (state_q != S_IDLE);
		cmd.last = (state_q != S_IDLE) && (state_d == S_IDLE);
		case (state_q)
			S_CMD:     cmd.sel = nccs_pkg::SEL_CMD;
			S_COL0:    cmd.sel = nccs_pkg::SEL_COL0;
			S_COL1:    cmd.sel = nccs_pkg::SEL_COL1;
			S_ROW0:    cmd.sel = nccs_pkg::SEL_ROW0;
			S_ROW1:    cmd.sel = nccs_pkg::SEL_ROW1;
			S_ROW2:    cmd.sel = nccs_pkg::SEL_ROW2;
			S_CTRL:    cmd.sel = nccs_pkg::SEL_CTRL;
			S_CTRL2:   cmd.sel = nccs_pkg::SEL_CTRL;
			S_DLY_PRE: cmd.sel = nccs_pkg::SEL_DELAY;
			S_DLY:     cmd.sel = nccs_pkg::SEL_DELAY;
			S_CMD2:    cmd.sel = nccs_pkg::SEL_CMD2;
			S_POLL:    cmd.sel = nccs_pkg::SEL_POLL;
			default:   cmd.sel = nccs_pkg::SEL_CMD;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== sv/nccs_datapath.sv =====
// Datapath of the NAND command cycle sequencer.
// Holds the request, the configuration registers and the result register; depends on nccs_pkg.
`timescale 1ns / 1ps

module nccs_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  nccs_pkg::cmd_t                       cmd,
	output nccs_pkg::status_t                    status,
	input  logic [7:0]                           opcode,
	input  logic                                 column_present,
	input  logic [15:0]                          column_address,
	input  logic                                 row_present,
	input  logic [23:0]                          row_address,
	input  logic                                 cfg_we,
	input  logic [nccs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nccs_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                 strobe,
	output logic [1:0]                           kind,
	output logic [7:0]                           bus_byte,
	output logic                                 cle,
	output logic                                 ale,
	output logic                                 chip_enable,
	output logic                                 ctrl_change,
	output logic [9:0]                           delay_us,
	output logic                                 last
);

	logic [7:0]  op_q;
	logic        colp_q;
	logic [15:0] col_q;
	logic        rowp_q;
	logic [23:0] row_q;

	logic [9:0]  chip_delay_q;
	logic        wide_bus_q;
	logic [15:0] capacity_q;

	logic        strobe_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic        cle_q;
	logic        ale_q;
	logic        ce_q;
	logic        chg_q;
	logic [9:0]  delay_q;
	logic        last_q;

	logic [15:0] col_eff;
	logic [1:0]  kind_d;
	logic [7:0]  byte_d;
	logic        cle_d;
	logic        ale_d;
	logic        ce_d;
	logic        chg_d;
	logic [9:0]  delay_d;

	// Request register, loaded on the input transfer.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			colp_q <= column_present;
			col_q  <= column_address;
			rowp_q <= row_present;
			row_q  <= row_address;
		end
	end

	// Configuration registers; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_delay_q <= nccs_pkg::CHIP_DELAY_RESET;
			wide_bus_q   <= 1'b0;
			capacity_q   <= nccs_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				nccs_pkg::CFG_CHIP_DELAY: chip_delay_q <= cfg_data[9:0];
				nccs_pkg::CFG_WIDE_BUS:   wide_bus_q   <= cfg_data[0];
				nccs_pkg::CFG_CAPACITY:   capacity_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Status for the controller.
	always_comb begin
		status.col_present = colp_q;
		status.row_present = rowp_q;
		status.third_row   = (capacity_q > nccs_pkg::BIG_CAPACITY_MB);
		if (op_q inside {nccs_pkg::OP_ERASE1, nccs_pkg::OP_ERASE2,
				nccs_pkg::OP_SEQIN, nccs_pkg::OP_PAGEPROG}) begin
			status.op_class = nccs_pkg::OPC_END;
		end else if (op_q == nccs_pkg::OP_RESET) begin
			status.op_class = nccs_pkg::OPC_RESET;
		end else if (op_q == nccs_pkg::OP_READ0) begin
			status.op_class = nccs_pkg::OPC_READ0;
		end else begin
			status.op_class = nccs_pkg::OPC_OTHER;
		end
	end

	// On a 16-bit bus the column is sent in words.
	assign col_eff = wide_bus_q ? {1'b0, col_q[15:1]} : col_q;

	// Build the selected item.
	always_comb begin
		kind_d  = nccs_pkg::KIND_BUS;
		byte_d  = 8'h00;
		cle_d   = 1'b0;
		ale_d   = 1'b0;
		ce_d    = 1'b1;
		chg_d   = 1'b0;
		delay_d = 10'd0;
		case (cmd.sel)
			nccs_pkg::SEL_CMD: begin
				byte_d = op_q;
				cle_d  = 1'b1;
				chg_d  = 1'b1;
			end
			nccs_pkg::SEL_COL0: begin
				byte_d = col_eff[7:0];
				ale_d  = 1'b1;
				chg_d  = 1'b1;
			end
			nccs_pkg::SEL_COL1: begin
				byte_d = col_eff[15:8];
				ale_d  = 1'b1;
			end
			nccs_pkg::SEL_ROW0: begin
				byte_d = row_q[7:0];
				ale_d  = 1'b1;
				chg_d  = !colp_q;
			end
			nccs_pkg::SEL_ROW1: begin
				byte_d = row_q[15:8];
				ale_d  = 1'b1;
			end
			nccs_pkg::SEL_ROW2: begin
				byte_d = row_q[23:16];
				ale_d  = 1'b1;
			end
			nccs_pkg::SEL_CTRL: begin
				kind_d = nccs_pkg::KIND_CTRL;
				chg_d  = 1'b1;
			end
			nccs_pkg::SEL_DELAY: begin
				kind_d  = nccs_pkg::KIND_DELAY;
				ce_d    = 1'b0;
				delay_d = chip_delay_q;
			end
			nccs_pkg::SEL_CMD2: begin
				byte_d = (op_q == nccs_pkg::OP_RESET) ? nccs_pkg::OP_STATUS
					: nccs_pkg::OP_READSTART;
				cle_d  = 1'b1;
				chg_d  = 1'b1;
			end
			nccs_pkg::SEL_POLL: begin
				kind_d = nccs_pkg::KIND_POLL;
				ce_d   = 1'b0;
			end
			default: ;
		endcase
	end

	// Result register: each item is shown for exactly one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q  <= kind_d;
			byte_q  <= byte_d;
			cle_q   <= cle_d;
			ale_q   <= ale_d;
			ce_q    <= ce_d;
			chg_q   <= chg_d;
			delay_q <= delay_d;
			last_q  <= cmd.last;
		end
	end

	assign strobe      = strobe_q;
	assign kind        = kind_q;
	assign bus_byte    = byte_q;
	assign cle         = cle_q;
	assign ale         = ale_q;
	assign chip_enable = ce_q;
	assign ctrl_change = chg_q;
	assign delay_us    = delay_q;
	assign last        = last_q;

endmodule

// ===== sv/nand_command_cycle_sequencer_core.sv =====
// NAND command cycle sequencer, top level: expands one command into its bus cycles.
// The start transfer passes through the controller's state register and then the result register
// before the first item is on the result ports; then one item a cycle follows. A command of n items
// (2 to 11) is walked by the controller one state per item; busy is low again on the cycle
// the last item is shown. Results cannot be stalled. Reset is asynchronous and active low;
// it returns the registers to 25 us delay, 8-bit bus and 512 MB. Depends on nccs_pkg.
`timescale 1ns / 1ps

module nand_command_cycle_sequencer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [7:0]                      opcode,
	input  logic                            column_present,
	input  logic [15:0]                     column_address,
	input  logic                            row_present,
	input  logic [23:0]                     row_address,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nccs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nccs_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            strobe,
	output logic [1:0]                      kind,
	output logic [7:0]                      bus_byte,
	output logic                            cle,
	output logic                            ale,
	output logic                            chip_enable,
	output logic                            ctrl_change,
	output logic [9:0]                      delay_us,
	output logic                            last
);

	nccs_pkg::cmd_t    cmd;
	nccs_pkg::status_t status;

	// Register writes are taken in any cycle.
	assign cfg_ready = 1'b1;

	nccs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	nccs_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.opcode         (opcode),
		.column_present (column_present),
		.column_address (column_address),
		.row_present    (row_present),
		.row_address    (row_address),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.strobe         (strobe),
		.kind           (kind),
		.bus_byte       (bus_byte),
		.cle            (cle),
		.ale            (ale),
		.chip_enable    (chip_enable),
		.ctrl_change    (ctrl_change),
		.delay_us       (delay_us),
		.last           (last)
	);

	// An accepted command keeps the block busy in the following cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a start transfer");

	// The final item of a command is never followed straight by another item.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("item shown straight after the last item");

	// Delay and poll items drive no bus lines.
	a_marker_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == nccs_pkg::KIND_DELAY || kind == nccs_pkg::KIND_POLL)
		|-> (bus_byte == 8'h00) && !cle && !ale && !chip_enable && !ctrl_change)
		else $error("marker item drives bus lines");

	// Only delay items carry a delay, and no cycle latches command and address together.
	a_delay_cle_ale: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(cle && ale) && ((kind == nccs_pkg::KIND_DELAY) || (delay_us == 10'd0)))
		else $error("bad control lines or stray delay value");

	// A new item appears only while busy or on the cycle in which busy falls.
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("item shown without a command in progress");

endmodule
